// File: src/dcfa_pkg.sv
// shared types, constants and elaboration-time helpers for the diagonal cfa green interpolator
// no dependencies; used by every module of the block
package dcfa_pkg;

    localparam int MAX_DIM_DEF          = 8192;
    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int COORD_W    = 13;
    localparam int IMG_DIM_W  = 14;
    localparam int SNS_DIM_W  = 13;
    localparam int POS_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam int NBR_N      = 6;
    localparam int TUSER_W    = 3;

    localparam int IMG_DIM_RESET = 4096;
    localparam int SNS_DIM_RESET = 2048;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_SENSOR_WIDTH,
        REG_SENSOR_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_BLANK,
        CLS_GREEN,
        CLS_RED,
        CLS_BLUE
    } site_class_t;

    typedef enum logic [1:0] {
        EDGE_NONE,
        EDGE_LEFT,
        EDGE_RIGHT
    } edge_mode_t;

    typedef struct packed {
        logic        valid;
        site_class_t cls;
        edge_mode_t  mode;
    } ctrl_t;

    // neighbour order: north, northeast, northwest, south, southeast, southwest
    localparam int NBR_NE = 1;
    localparam int NBR_NW = 2;
    localparam int NBR_SE = 4;
    localparam int NBR_SW = 5;
    localparam logic [NBR_N-1:0] NBR_ORTHO = 6'b001001;
    localparam int NBR_DX [NBR_N] = '{0, 1, -1, 0, 1, -1};
    localparam int NBR_DY [NBR_N] = '{-1, -1, -1, 1, 1, 1};

    // round(2^frac / sqrt(2)) as the rounded integer square root of 2^(2*frac-1)
    function automatic logic [63:0] diag_weight(input int frac);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] t;
        n = 64'd1 << (2 * frac - 1);
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) begin
                r = t;
            end
        end
        if (n > r * r + r) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    // dimension register values above the cap are held at the cap
    function automatic logic [IMG_DIM_W-1:0] clamp_dim(input logic [IMG_DIM_W-1:0] v,
                                                        input int cap);
        return (int'(v) > cap) ? IMG_DIM_W'(cap) : v;
    endfunction

endpackage

// File: src/dcfa_site.sv
// input register and site classification stage
// classifies the centre pixel and marks which neighbours are non-blank; uses dcfa_pkg
module dcfa_site #(
    parameter int SAMPLE_BITS = dcfa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          ce,
    input  logic                                          in_valid,
    input  logic [dcfa_pkg::COORD_W-1:0]                  col,
    input  logic [dcfa_pkg::COORD_W-1:0]                  row,
    input  logic [SAMPLE_BITS-1:0]                        center,
    input  logic [dcfa_pkg::NBR_N-1:0][SAMPLE_BITS-1:0]   nbr,
    input  logic [dcfa_pkg::IMG_DIM_W-1:0]                image_width,
    input  logic [dcfa_pkg::IMG_DIM_W-1:0]                image_height,
    input  logic [dcfa_pkg::SNS_DIM_W-1:0]                sensor_width,
    input  logic [dcfa_pkg::SNS_DIM_W-1:0]                sensor_height,
    output dcfa_pkg::ctrl_t                               ctrl_out,
    output logic [dcfa_pkg::NBR_N-1:0]                    present_out,
    output logic [dcfa_pkg::NBR_N-1:0][SAMPLE_BITS-1:0]   nbr_out,
    output logic [SAMPLE_BITS-1:0]                        center_out
);

    localparam int POS_W = dcfa_pkg::POS_W;
    localparam int NBR_N = dcfa_pkg::NBR_N;

    function automatic logic in_image(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic [dcfa_pkg::IMG_DIM_W-1:0] w,
                                      input logic [dcfa_pkg::IMG_DIM_W-1:0] h);
        logic signed [POS_W-1:0] w_s;
        logic signed [POS_W-1:0] h_s;
        w_s = $signed(POS_W'(w));
        h_s = $signed(POS_W'(h));
        return (x >= 0) && (y >= 0) && (x < w_s) && (y < h_s);
    endfunction

    // four diagonal boundary lines of the active area
    function automatic logic in_diamond(input logic signed [POS_W-1:0] x,
                                        input logic signed [POS_W-1:0] y,
                                        input logic [dcfa_pkg::SNS_DIM_W-1:0] sw,
                                        input logic [dcfa_pkg::SNS_DIM_W-1:0] sh);
        logic signed [POS_W-1:0] sw_s;
        logic signed [POS_W-1:0] sh_s;
        logic signed [POS_W-1:0] sum1;
        sw_s = $signed(POS_W'(sw));
        sh_s = $signed(POS_W'(sh));
        sum1 = x + y + POS_W'(1);
        return (sum1 >= sw_s) && (y + sw_s >= x) && (sum1 < sw_s + (sh_s <<< 1))
            && (x + sw_s > y);
    endfunction

    // stage 1: input register
    logic                                 valid_s1_reg;
    logic [dcfa_pkg::COORD_W-1:0]         col_reg;
    logic [dcfa_pkg::COORD_W-1:0]         row_reg;
    logic [SAMPLE_BITS-1:0]               center_s1_reg;
    logic [NBR_N-1:0][SAMPLE_BITS-1:0]    nbr_s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_s1_reg <= 1'b0;
        end else if (ce) begin
            valid_s1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            col_reg       <= col;
            row_reg       <= row;
            center_s1_reg <= center;
            nbr_s1_reg    <= nbr;
        end
    end

    // stage 2: classification
    logic signed [POS_W-1:0]              x_c;
    logic signed [POS_W-1:0]              y_c;
    logic signed [POS_W-1:0]              nx_c [NBR_N];
    logic signed [POS_W-1:0]              ny_c [NBR_N];
    logic [NBR_N-1:0]                     inimg_c;
    logic [NBR_N-1:0]                     present_next;
    logic [NBR_N-1:0][SAMPLE_BITS-1:0]    nbr_next;
    dcfa_pkg::ctrl_t                      ctrl_next;
    logic                                 inside_c;

    always_comb begin
        x_c = $signed(POS_W'(col_reg));
        y_c = $signed(POS_W'(row_reg));
        inside_c = in_image(x_c, y_c, image_width, image_height)
                && in_diamond(x_c, y_c, sensor_width, sensor_height);
        for (int i = 0; i < NBR_N; i++) begin
            nx_c[i] = x_c + POS_W'(dcfa_pkg::NBR_DX[i]);
            ny_c[i] = y_c + POS_W'(dcfa_pkg::NBR_DY[i]);
            inimg_c[i] = in_image(nx_c[i], ny_c[i], image_width, image_height);
            present_next[i] = inimg_c[i]
                           && in_diamond(nx_c[i], ny_c[i], sensor_width, sensor_height);
            nbr_next[i] = inimg_c[i] ? nbr_s1_reg[i] : '0;
        end

        ctrl_next.valid = valid_s1_reg;
        priority if (!inside_c) begin
            ctrl_next.cls = dcfa_pkg::CLS_BLANK;
        end else if (!row_reg[0]) begin
            ctrl_next.cls = dcfa_pkg::CLS_GREEN;
        end else if (col_reg[1] == row_reg[1]) begin
            ctrl_next.cls = dcfa_pkg::CLS_BLUE;
        end else begin
            ctrl_next.cls = dcfa_pkg::CLS_RED;
        end

        // left column wins over right column
        priority if (col_reg == '0) begin
            ctrl_next.mode = dcfa_pkg::EDGE_LEFT;
        end else if (dcfa_pkg::IMG_DIM_W'(col_reg) == image_width - 1'b1) begin
            ctrl_next.mode = dcfa_pkg::EDGE_RIGHT;
        end else begin
            ctrl_next.mode = dcfa_pkg::EDGE_NONE;
        end
    end

    dcfa_pkg::ctrl_t                      ctrl_reg;
    logic [NBR_N-1:0]                     present_reg;
    logic [NBR_N-1:0][SAMPLE_BITS-1:0]    nbr_reg;
    logic [SAMPLE_BITS-1:0]               center_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (ce) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            present_reg <= present_next;
            nbr_reg     <= nbr_next;
            center_reg  <= center_s1_reg;
        end
    end

    assign ctrl_out    = ctrl_reg;
    assign present_out = present_reg;
    assign nbr_out     = nbr_reg;
    assign center_out  = center_reg;

endmodule

// File: src/dcfa_accum.sv
// weighting and accumulation stages: weighted terms, weight sum, edge-column mean
// three register stages; uses dcfa_pkg
module dcfa_accum #(
    parameter int SAMPLE_BITS      = dcfa_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = dcfa_pkg::WEIGHT_FRAC_BITS_DEF,
    localparam int NUM_W           = SAMPLE_BITS + WEIGHT_FRAC_BITS + 3,
    localparam int DEN_W           = WEIGHT_FRAC_BITS + 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          ce,
    input  dcfa_pkg::ctrl_t                               ctrl_in,
    input  logic [dcfa_pkg::NBR_N-1:0]                    present,
    input  logic [dcfa_pkg::NBR_N-1:0][SAMPLE_BITS-1:0]   nbr,
    input  logic [SAMPLE_BITS-1:0]                        center_in,
    output dcfa_pkg::ctrl_t                               ctrl_out,
    output logic [NUM_W-1:0]                              num,
    output logic [DEN_W-1:0]                              den,
    output logic [SAMPLE_BITS-1:0]                        edge_mean,
    output logic [SAMPLE_BITS-1:0]                        center_out
);

    localparam int NBR_N  = dcfa_pkg::NBR_N;
    localparam int F      = WEIGHT_FRAC_BITS;
    localparam int TERM_W = SAMPLE_BITS + F;
    localparam int HALF_W = TERM_W + 2;
    localparam logic [F-1:0] DW = F'(dcfa_pkg::diag_weight(F));

    // stage 3: weighted terms and weight sum
    logic [TERM_W-1:0]      term_next [NBR_N];
    logic [1:0]             cnt_ortho;
    logic [2:0]             cnt_diag;
    logic [DEN_W-1:0]       den_next;
    logic [SAMPLE_BITS:0]   edge_sum;
    logic [SAMPLE_BITS-1:0] edge_next;

    always_comb begin
        for (int i = 0; i < NBR_N; i++) begin
            if (!present[i]) begin
                term_next[i] = '0;
            end else if (dcfa_pkg::NBR_ORTHO[i]) begin
                term_next[i] = TERM_W'(nbr[i]) << F;
            end else begin
                term_next[i] = TERM_W'(nbr[i]) * TERM_W'(DW);
            end
        end
        cnt_ortho = 2'($countones(present & dcfa_pkg::NBR_ORTHO));
        cnt_diag  = 3'($countones(present & ~dcfa_pkg::NBR_ORTHO));
        den_next  = (DEN_W'(cnt_ortho) << F) + DEN_W'(cnt_diag) * DEN_W'(DW);

        unique case (ctrl_in.mode)
            dcfa_pkg::EDGE_LEFT: begin
                edge_sum = (SAMPLE_BITS + 1)'(nbr[dcfa_pkg::NBR_NE])
                         + (SAMPLE_BITS + 1)'(nbr[dcfa_pkg::NBR_SE]) + 1'b1;
            end
            dcfa_pkg::EDGE_RIGHT: begin
                edge_sum = (SAMPLE_BITS + 1)'(nbr[dcfa_pkg::NBR_NW])
                         + (SAMPLE_BITS + 1)'(nbr[dcfa_pkg::NBR_SW]) + 1'b1;
            end
            default: begin
                edge_sum = '0;
            end
        endcase
        edge_next = edge_sum[SAMPLE_BITS:1];
    end

    dcfa_pkg::ctrl_t        ctrl_s3_reg;
    logic [TERM_W-1:0]      term_reg [NBR_N];
    logic [DEN_W-1:0]       den_s3_reg;
    logic [SAMPLE_BITS-1:0] edge_s3_reg;
    logic [SAMPLE_BITS-1:0] center_s3_reg;

    // stage 4: two partial sums
    logic [HALF_W-1:0]      half_next [2];

    always_comb begin
        half_next[0] = HALF_W'(term_reg[0]) + HALF_W'(term_reg[1]) + HALF_W'(term_reg[2]);
        half_next[1] = HALF_W'(term_reg[3]) + HALF_W'(term_reg[4]) + HALF_W'(term_reg[5]);
    end

    dcfa_pkg::ctrl_t        ctrl_s4_reg;
    logic [HALF_W-1:0]      half_reg [2];
    logic [DEN_W-1:0]       den_s4_reg;
    logic [SAMPLE_BITS-1:0] edge_s4_reg;
    logic [SAMPLE_BITS-1:0] center_s4_reg;

    // stage 5: numerator with the rounding half
    logic [NUM_W-1:0]       num_next;

    assign num_next = NUM_W'(half_reg[0]) + NUM_W'(half_reg[1]) + NUM_W'(den_s4_reg >> 1);

    dcfa_pkg::ctrl_t        ctrl_s5_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [DEN_W-1:0]       den_s5_reg;
    logic [SAMPLE_BITS-1:0] edge_s5_reg;
    logic [SAMPLE_BITS-1:0] center_s5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_s3_reg <= '0;
            ctrl_s4_reg <= '0;
            ctrl_s5_reg <= '0;
        end else if (ce) begin
            ctrl_s3_reg <= ctrl_in;
            ctrl_s4_reg <= ctrl_s3_reg;
            ctrl_s5_reg <= ctrl_s4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            term_reg      <= term_next;
            den_s3_reg    <= den_next;
            edge_s3_reg   <= edge_next;
            center_s3_reg <= center_in;

            half_reg      <= half_next;
            den_s4_reg    <= den_s3_reg;
            edge_s4_reg   <= edge_s3_reg;
            center_s4_reg <= center_s3_reg;

            num_reg       <= num_next;
            den_s5_reg    <= den_s4_reg;
            edge_s5_reg   <= edge_s4_reg;
            center_s5_reg <= center_s4_reg;
        end
    end

    assign ctrl_out   = ctrl_s5_reg;
    assign num        = num_reg;
    assign den        = den_s5_reg;
    assign edge_mean  = edge_s5_reg;
    assign center_out = center_s5_reg;

endmodule

// File: src/dcfa_div.sv
// pipelined restoring divider, one quotient bit per register stage
// carries the item's side information alongside; uses dcfa_pkg
module dcfa_div #(
    parameter int SAMPLE_BITS      = dcfa_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = dcfa_pkg::WEIGHT_FRAC_BITS_DEF,
    localparam int NUM_W           = SAMPLE_BITS + WEIGHT_FRAC_BITS + 3,
    localparam int DEN_W           = WEIGHT_FRAC_BITS + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  dcfa_pkg::ctrl_t        ctrl_in,
    input  logic [NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SAMPLE_BITS-1:0] edge_in,
    input  logic [SAMPLE_BITS-1:0] center_in,
    output dcfa_pkg::ctrl_t        ctrl_out,
    output logic [SAMPLE_BITS-1:0] quotient,
    output logic                   den_zero,
    output logic [SAMPLE_BITS-1:0] edge_out,
    output logic [SAMPLE_BITS-1:0] center_out
);

    localparam int SB = SAMPLE_BITS;

    dcfa_pkg::ctrl_t  ctrl_cur   [SB];
    logic [NUM_W-1:0] rem_cur    [SB];
    logic [DEN_W-1:0] den_cur    [SB];
    logic [SB-1:0]    q_cur      [SB];
    logic [SB-1:0]    edge_cur   [SB];
    logic [SB-1:0]    center_cur [SB];

    dcfa_pkg::ctrl_t  ctrl_reg   [SB];
    logic [NUM_W-1:0] rem_reg    [SB];
    logic [DEN_W-1:0] den_reg    [SB];
    logic [SB-1:0]    q_reg      [SB];
    logic [SB-1:0]    edge_reg   [SB];
    logic [SB-1:0]    center_reg [SB];

    logic [NUM_W-1:0] rem_next   [SB];
    logic [SB-1:0]    q_next     [SB];

    always_comb begin
        ctrl_cur[0]   = ctrl_in;
        rem_cur[0]    = num;
        den_cur[0]    = den;
        q_cur[0]      = '0;
        edge_cur[0]   = edge_in;
        center_cur[0] = center_in;
        for (int i = 1; i < SB; i++) begin
            ctrl_cur[i]   = ctrl_reg[i-1];
            rem_cur[i]    = rem_reg[i-1];
            den_cur[i]    = den_reg[i-1];
            q_cur[i]      = q_reg[i-1];
            edge_cur[i]   = edge_reg[i-1];
            center_cur[i] = center_reg[i-1];
        end
    end

    for (genvar i = 0; i < SB; i++) begin : g_stage
        localparam int K = SB - 1 - i;
        logic [NUM_W-1:0] den_shift;
        logic             fits;

        // quotient stays below 2^SB, so testing from bit SB-1 down is enough
        assign den_shift   = NUM_W'(den_cur[i]) << K;
        assign fits        = rem_cur[i] >= den_shift;
        assign rem_next[i] = fits ? rem_cur[i] - den_shift : rem_cur[i];
        assign q_next[i]   = q_cur[i] | (fits ? (SB'(1) << K) : '0);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[i] <= '0;
            end else if (ce) begin
                ctrl_reg[i] <= ctrl_cur[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i]    <= rem_next[i];
                den_reg[i]    <= den_cur[i];
                q_reg[i]      <= q_next[i];
                edge_reg[i]   <= edge_cur[i];
                center_reg[i] <= center_cur[i];
            end
        end
    end

    assign ctrl_out   = ctrl_reg[SB-1];
    assign quotient   = q_reg[SB-1];
    assign den_zero   = (den_reg[SB-1] == '0);
    assign edge_out   = edge_reg[SB-1];
    assign center_out = center_reg[SB-1];

endmodule

// File: src/diagonal_cfa_green_idw_interpolator_unit.sv
// Green interpolation for a 45-degree rotated colour sensor, one pixel neighbourhood per clock
// while the result side does not stall. The pipeline has two stages for input capture and site
// classification, three for weighting and summing, one per quotient bit in the restoring divider,
// and the output register. The divider, one bit per stage, sets the depth. A stall on the result
// side freezes every stage at once, so s_tready follows m_tready whenever a result is waiting.
// Image dimension writes above MAX_DIM are held at MAX_DIM; sensor dimension writes keep only the
// low SNS_DIM_W bits before that clamp; write them only while the pipeline is empty.
// depends on dcfa_pkg, dcfa_site, dcfa_accum and dcfa_div
module diagonal_cfa_green_idw_interpolator_unit #(
    parameter int MAX_DIM          = dcfa_pkg::MAX_DIM_DEF,
    parameter int SAMPLE_BITS      = dcfa_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = dcfa_pkg::WEIGHT_FRAC_BITS_DEF,
    localparam int IN_W  = ((2 * dcfa_pkg::COORD_W + 7 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dcfa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dcfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // col, row, center_sample, north_sample, northeast_sample, northwest_sample,
    // south_sample, southeast_sample, southwest_sample, zero fill
    input  logic [IN_W-1:0]                   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // green_value, raw_passthrough, zero fill
    output logic [OUT_W-1:0]                  m_tdata,
    // site_class, no_neighbor_flag
    output logic [dcfa_pkg::TUSER_W-1:0]      m_tuser
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = dcfa_pkg::COORD_W;
    localparam int NBR_N = dcfa_pkg::NBR_N;
    localparam int NUM_W = SAMPLE_BITS + WEIGHT_FRAC_BITS + 3;
    localparam int DEN_W = WEIGHT_FRAC_BITS + 3;

    // configuration registers
    logic [dcfa_pkg::IMG_DIM_W-1:0] image_width_reg;
    logic [dcfa_pkg::IMG_DIM_W-1:0] image_height_reg;
    logic [dcfa_pkg::SNS_DIM_W-1:0] sensor_width_reg;
    logic [dcfa_pkg::SNS_DIM_W-1:0] sensor_height_reg;
    logic [dcfa_pkg::IMG_DIM_W-1:0] img_dim_next;
    logic [dcfa_pkg::IMG_DIM_W-1:0] sns_dim_next;

    assign img_dim_next = dcfa_pkg::clamp_dim(cfg_wdata, MAX_DIM);
    assign sns_dim_next = dcfa_pkg::clamp_dim(
        dcfa_pkg::IMG_DIM_W'(cfg_wdata[dcfa_pkg::SNS_DIM_W-1:0]), MAX_DIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= dcfa_pkg::clamp_dim(
                dcfa_pkg::IMG_DIM_W'(dcfa_pkg::IMG_DIM_RESET), MAX_DIM);
            image_height_reg  <= dcfa_pkg::clamp_dim(
                dcfa_pkg::IMG_DIM_W'(dcfa_pkg::IMG_DIM_RESET), MAX_DIM);
            sensor_width_reg  <= dcfa_pkg::SNS_DIM_W'(dcfa_pkg::clamp_dim(
                dcfa_pkg::IMG_DIM_W'(dcfa_pkg::SNS_DIM_RESET), MAX_DIM));
            sensor_height_reg <= dcfa_pkg::SNS_DIM_W'(dcfa_pkg::clamp_dim(
                dcfa_pkg::IMG_DIM_W'(dcfa_pkg::SNS_DIM_RESET), MAX_DIM));
        end else if (cfg_wr_en) begin
            unique case (dcfa_pkg::cfg_reg_t'(cfg_addr))
                dcfa_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= img_dim_next;
                dcfa_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= img_dim_next;
                dcfa_pkg::REG_SENSOR_WIDTH:  sensor_width_reg  <= sns_dim_next[dcfa_pkg::SNS_DIM_W-1:0];
                dcfa_pkg::REG_SENSOR_HEIGHT: sensor_height_reg <= sns_dim_next[dcfa_pkg::SNS_DIM_W-1:0];
            endcase
        end
    end

    // global advance: every stage moves unless a finished result is held back
    logic ce;
    logic m_tvalid_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    logic [CW-1:0]                 in_col;
    logic [CW-1:0]                 in_row;
    logic [SB-1:0]                 in_center;
    logic [NBR_N-1:0][SB-1:0]      in_nbr;

    assign in_col    = s_tdata[CW-1:0];
    assign in_row    = s_tdata[2*CW-1:CW];
    assign in_center = s_tdata[2*CW +: SB];
    assign in_nbr    = s_tdata[2*CW + SB +: NBR_N * SB];

    dcfa_pkg::ctrl_t               site_ctrl;
    logic [NBR_N-1:0]              site_present;
    logic [NBR_N-1:0][SB-1:0]      site_nbr;
    logic [SB-1:0]                 site_center;

    dcfa_site #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_site (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .in_valid      (s_tvalid),
        .col           (in_col),
        .row           (in_row),
        .center        (in_center),
        .nbr           (in_nbr),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .sensor_width  (sensor_width_reg),
        .sensor_height (sensor_height_reg),
        .ctrl_out      (site_ctrl),
        .present_out   (site_present),
        .nbr_out       (site_nbr),
        .center_out    (site_center)
    );

    dcfa_pkg::ctrl_t               acc_ctrl;
    logic [NUM_W-1:0]              acc_num;
    logic [DEN_W-1:0]              acc_den;
    logic [SB-1:0]                 acc_edge;
    logic [SB-1:0]                 acc_center;

    dcfa_accum #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .ctrl_in    (site_ctrl),
        .present    (site_present),
        .nbr        (site_nbr),
        .center_in  (site_center),
        .ctrl_out   (acc_ctrl),
        .num        (acc_num),
        .den        (acc_den),
        .edge_mean  (acc_edge),
        .center_out (acc_center)
    );

    dcfa_pkg::ctrl_t               div_ctrl;
    logic [SB-1:0]                 div_quotient;
    logic                          div_den_zero;
    logic [SB-1:0]                 div_edge;
    logic [SB-1:0]                 div_center;

    dcfa_div #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .ctrl_in    (acc_ctrl),
        .num        (acc_num),
        .den        (acc_den),
        .edge_in    (acc_edge),
        .center_in  (acc_center),
        .ctrl_out   (div_ctrl),
        .quotient   (div_quotient),
        .den_zero   (div_den_zero),
        .edge_out   (div_edge),
        .center_out (div_center)
    );

    // output selection and register
    logic [SB-1:0]          green_next;
    logic                   flag_next;
    logic [SB-1:0]          green_reg;
    logic [SB-1:0]          raw_reg;
    dcfa_pkg::site_class_t  cls_reg;
    logic                   flag_reg;

    always_comb begin
        green_next = div_center;
        flag_next  = 1'b0;
        if (div_ctrl.cls == dcfa_pkg::CLS_RED || div_ctrl.cls == dcfa_pkg::CLS_BLUE) begin
            unique case (div_ctrl.mode)
                dcfa_pkg::EDGE_LEFT, dcfa_pkg::EDGE_RIGHT: begin
                    green_next = div_edge;
                end
                default: begin
                    if (div_den_zero) begin
                        green_next = '0;
                        flag_next  = 1'b1;
                    end else begin
                        green_next = div_quotient;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= div_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            green_reg <= green_next;
            raw_reg   <= div_center;
            cls_reg   <= div_ctrl.cls;
            flag_reg  <= flag_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({raw_reg, green_reg});
    assign m_tuser  = {flag_reg, cls_reg};

    // a held result must stop the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while a result is held");

    // blank and green sites pass the raw sample through
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (cls_reg == dcfa_pkg::CLS_BLANK || cls_reg == dcfa_pkg::CLS_GREEN))
        |-> (green_reg == raw_reg && !flag_reg))
        else $error("non-interpolated site altered");

    // the no-neighbour flag comes with a zero green value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && flag_reg) |-> (green_reg == '0))
        else $error("no-neighbour flag with non-zero green");

    // a stalled result keeps its green value and site class
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(m_tvalid && !m_tready)) |-> ($stable(green_reg) && $stable(cls_reg)))
        else $error("stalled result changed");

endmodule
